// File: hdl/mpd_pkg.sv
// ----------------------------------------------------------------------------
// mpd_pkg
// Types and codes shared by the MQTT PUBLISH deframer.
// ----------------------------------------------------------------------------
package mpd_pkg;

    localparam int MAX_LENGTH_BYTES_DEF = 4;
    localparam int LEN_IDX_W            = 2;
    localparam int TOPIC_LEN_W          = 16;
    localparam int TDATA_IN_W           = 8;
    localparam int TDATA_OUT_W          = 32;

    localparam logic [7:0] HDR_QOS0  = 8'h30;
    localparam logic [7:0] HDR_QOS1  = 8'h32;
    localparam logic [7:0] HDR_QOS2  = 8'h34;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_LEN     = 3'd1,
        PH_TLEN_HI = 3'd2,
        PH_TLEN_LO = 3'd3,
        PH_TOPIC   = 3'd4,
        PH_PKTID   = 3'd5,
        PH_PAYLOAD = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        KIND_OTHER   = 2'd0,
        KIND_TOPIC   = 2'd1,
        KIND_PAYLOAD = 2'd2,
        KIND_ERROR   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE        = 2'd0,
        ERR_NOT_PUBLISH = 2'd1,
        ERR_LEN_LONG    = 2'd2,
        ERR_LEN_BAD     = 2'd3
    } t_err;

endpackage

// File: hdl/mqtt_publish_deframer.sv
// ----------------------------------------------------------------------------
// mqtt_publish_deframer
// Parses MQTT PUBLISH packets a byte at a time and tags each byte.
// Each byte passes the input register and then the result register.
// Throughput: one item per cycle when m_axis_tready allows; the per-byte parse
// is a single pass between the input register and the result register.
// Reset (synchronous, active low) clears the parse state and both valid flags.
// ----------------------------------------------------------------------------
module mqtt_publish_deframer
    import mpd_pkg::*;
#(
    parameter int MAX_LENGTH_BYTES = MAX_LENGTH_BYTES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [TDATA_IN_W-1:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic                   s_axis_tuser,   // [0] packet_start
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [7:0] out_byte, [23:8] topic_length, [24] qos_nonzero,
    // [26:25] error_code, [31:27] zero
    output logic [TDATA_OUT_W-1:0] m_axis_tdata,
    output logic [1:0]             m_axis_tuser,   // [1:0] byte_kind
    output logic                   m_axis_tlast    // packet_last
);

    localparam int RC_W  = 7 * MAX_LENGTH_BYTES;
    localparam int CMP_W = (RC_W > TOPIC_LEN_W + 1) ? RC_W : TOPIC_LEN_W + 1;

    // input stage
    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    logic                   r_in_start;

    // parse state
    t_phase                 r_phase,  n_phase;
    logic [RC_W-1:0]        r_rc,     n_rc;
    logic [LEN_IDX_W-1:0]   r_idx,    n_idx;
    logic [TOPIC_LEN_W-1:0] r_tlen,   n_tlen;
    logic [TOPIC_LEN_W-1:0] r_fc,     n_fc;
    logic                   r_qos,    n_qos;

    // result stage
    logic                   r_out_valid;
    t_kind                  r_out_kind, n_kind;
    logic [7:0]             r_out_byte;
    logic [TOPIC_LEN_W-1:0] r_out_tlen;
    logic                   r_out_qos;
    t_err                   r_out_err, n_err;
    logic                   r_out_last, n_last;

    logic                   adv;
    logic [RC_W-1:0]        rc_dec;
    logic [TOPIC_LEN_W-1:0] fc_dec;
    logic [CMP_W-1:0]       tlen_need;

    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;

    assign rc_dec = (r_rc != '0) ? r_rc - RC_W'(1) : r_rc;
    assign fc_dec = (r_fc != '0) ? r_fc - TOPIC_LEN_W'(1) : r_fc;

    always_comb begin
        logic hdr_ok;
        hdr_ok    = (r_in_byte == HDR_QOS0) || (r_in_byte == HDR_QOS1) ||
                    (r_in_byte == HDR_QOS2);
        n_phase   = r_phase;
        n_rc      = r_rc;
        n_idx     = r_idx;
        n_tlen    = r_tlen;
        n_fc      = r_fc;
        n_qos     = r_qos;
        n_kind    = KIND_OTHER;
        n_err     = ERR_NONE;
        n_last    = 1'b0;
        tlen_need = CMP_W'({r_tlen[TOPIC_LEN_W-1:8], r_in_byte}) +
                    CMP_W'({r_qos, 1'b0});

        if (r_in_start) begin
            n_rc   = '0;
            n_idx  = '0;
            n_tlen = '0;
            n_fc   = '0;
            if (hdr_ok) begin
                n_qos   = (r_in_byte != HDR_QOS0);
                n_phase = PH_LEN;
            end else begin
                n_qos = 1'b0;
                n_err = ERR_NOT_PUBLISH;
            end
        end else begin
            case (r_phase)
                PH_LEN: begin
                    for (int k = 0; k < MAX_LENGTH_BYTES; k++) begin
                        if (r_idx == LEN_IDX_W'(k))
                            n_rc[7*k +: 7] = r_rc[7*k +: 7] | r_in_byte[6:0];
                    end
                    if (r_in_byte[7]) begin
                        if ({1'b0, r_idx} + 3'd1 >= 3'(MAX_LENGTH_BYTES))
                            n_err = ERR_LEN_LONG;
                        else
                            n_idx = r_idx + LEN_IDX_W'(1);
                    end else begin
                        // 2 bytes of topic length, plus packet id with QoS
                        if (n_rc < RC_W'({r_qos, !r_qos, 1'b0}))
                            n_err = ERR_LEN_BAD;
                        else
                            n_phase = PH_TLEN_HI;
                    end
                end
                PH_TLEN_HI: begin
                    n_tlen  = {r_in_byte, 8'h00};
                    n_rc    = rc_dec;
                    n_phase = PH_TLEN_LO;
                end
                PH_TLEN_LO: begin
                    n_tlen = {r_tlen[TOPIC_LEN_W-1:8], r_in_byte};
                    n_rc   = rc_dec;
                    if (tlen_need > CMP_W'(rc_dec)) begin
                        n_err = ERR_LEN_BAD;
                    end else if (n_tlen != '0) begin
                        n_phase = PH_TOPIC;
                        n_fc    = n_tlen;
                    end else if (r_qos) begin
                        n_phase = PH_PKTID;
                        n_fc    = TOPIC_LEN_W'(2);
                    end else if (rc_dec != '0) begin
                        n_phase = PH_PAYLOAD;
                    end else begin
                        n_phase = PH_IDLE;
                        n_last  = 1'b1;
                    end
                end
                PH_TOPIC: begin
                    n_kind = KIND_TOPIC;
                    n_rc   = rc_dec;
                    n_fc   = fc_dec;
                    if (fc_dec == '0) begin
                        if (r_qos) begin
                            n_phase = PH_PKTID;
                            n_fc    = TOPIC_LEN_W'(2);
                        end else if (rc_dec != '0) begin
                            n_phase = PH_PAYLOAD;
                        end else begin
                            n_phase = PH_IDLE;
                            n_last  = 1'b1;
                        end
                    end
                end
                PH_PKTID: begin
                    n_rc = rc_dec;
                    n_fc = fc_dec;
                    if (fc_dec == '0) begin
                        if (rc_dec != '0) begin
                            n_phase = PH_PAYLOAD;
                        end else begin
                            n_phase = PH_IDLE;
                            n_last  = 1'b1;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    n_kind = KIND_PAYLOAD;
                    n_rc   = rc_dec;
                    if (rc_dec == '0) begin
                        n_phase = PH_IDLE;
                        n_last  = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end

        if (n_err != ERR_NONE) begin
            n_kind  = KIND_ERROR;
            n_last  = 1'b1;
            n_phase = PH_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_IDLE;
            r_rc        <= '0;
            r_idx       <= '0;
            r_tlen      <= '0;
            r_fc        <= '0;
            r_qos       <= 1'b0;
        end else begin
            if (s_axis_tready)
                r_in_valid <= s_axis_tvalid;
            if (!r_out_valid || m_axis_tready)
                r_out_valid <= r_in_valid;
            if (adv) begin
                r_phase <= n_phase;
                r_rc    <= n_rc;
                r_idx   <= n_idx;
                r_tlen  <= n_tlen;
                r_fc    <= n_fc;
                r_qos   <= n_qos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte  <= s_axis_tdata;
            r_in_start <= s_axis_tuser;
        end
        if (adv) begin
            r_out_kind <= n_kind;
            r_out_byte <= r_in_byte;
            r_out_tlen <= n_tlen;
            r_out_qos  <= n_qos;
            r_out_err  <= n_err;
            r_out_last <= n_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out_err, r_out_qos, r_out_tlen, r_out_byte};
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

    // an error always closes the packet
    a_err_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_err != ERR_NONE) |->
            (r_out_kind == KIND_ERROR) && r_out_last)
        else $error("error result without error kind or last");

    // a held input item stays put until the result stage takes it
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid && $stable(r_in_byte) && $stable(r_in_start))
        else $error("input stage lost a stalled item");

    // the topic phase always has bytes left to count
    a_topic_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_TOPIC) |-> (r_fc != '0))
        else $error("topic phase with zero byte count");

    // topic length stays clear until the length field is read
    a_tlen_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LEN) |-> (r_tlen == '0))
        else $error("topic length set during remaining length decode");

endmodule
